[hdl/epp_pkg.sv]
// Shared types and constants for the encoder preset positioner.
package epp_pkg;

    // Field widths of the items.
    localparam int CMD_W    = 2;
    localparam int IDX_W    = 7;
    localparam int POS_W    = 8;
    localparam int SPR_W    = 13;
    localparam int STEP_W   = 14;
    localparam int ACT_W    = 2;
    localparam int HOLD_W   = 5;

    // Default size of the preset table.
    localparam int EPP_NUM_PRESETS = 128;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MOVE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

    // Action codes reported with each result.
    localparam logic [ACT_W-1:0] ACT_NONE    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SAVED   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEARED = 2'd2;
    localparam logic [ACT_W-1:0] ACT_RESET   = 2'd3;

    // Quadrature transitions, written as {previous code, new code}.
    localparam logic [3:0] ENC_UP_0 = 4'b1101;
    localparam logic [3:0] ENC_UP_1 = 4'b0100;
    localparam logic [3:0] ENC_UP_2 = 4'b0010;
    localparam logic [3:0] ENC_UP_3 = 4'b1011;
    localparam logic [3:0] ENC_DN_0 = 4'b1110;
    localparam logic [3:0] ENC_DN_1 = 4'b0111;
    localparam logic [3:0] ENC_DN_2 = 4'b0001;
    localparam logic [3:0] ENC_DN_3 = 4'b1000;

    // Dial and preset constants.
    localparam logic [POS_W-1:0] NEUTRAL_POS = 8'd127;
    localparam logic [POS_W-1:0] UNSET_WORD  = 8'd255;
    localparam logic [SPR_W-1:0] SPR_RESET   = 13'd200;

    // Button hold tick numbers.
    localparam logic [HOLD_W-1:0] HOLD_SAVE  = 5'd2;
    localparam logic [HOLD_W-1:0] HOLD_CLEAR = 5'd7;
    localparam logic [HOLD_W-1:0] HOLD_RESET = 5'd11;
    localparam logic [HOLD_W-1:0] HOLD_WRAP  = 5'd16;

    // Step count: ceil(4*d*spr/360) = floor((d*spr + 89) / 90).
    // The division by 90 is a shift by one and an exact reciprocal of 45
    // for 20-bit operands: floor(y/45) = (y * RECIP_45) >> RECIP_SHIFT.
    localparam int PROD_W      = POS_W + SPR_W;   // d * spr
    localparam int HALF_W      = PROD_W - 1;      // (d * spr + 89) >> 1
    localparam int RECIP_W     = 21;
    localparam int BIG_W       = HALF_W + RECIP_W;
    localparam int RECIP_SHIFT = 26;
    localparam int QUOT_W      = BIG_W - RECIP_SHIFT;
    localparam logic [PROD_W:0]    ROUND_UP  = 22'd89;
    localparam logic [RECIP_W-1:0] RECIP_45  = 21'd1491309;
    localparam logic [QUOT_W-1:0]  STEP_MAX  = 15'd16383;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             pin_a;
        logic             pin_b;
        logic [IDX_W-1:0] preset_index;
        logic             button_pressed;
    } t_epp_in;

    typedef struct packed {
        logic              drive_valid;
        logic              direction;
        logic [STEP_W-1:0] step_count;
        logic [POS_W-1:0]  position;
        logic [ACT_W-1:0]  action_code;
    } t_epp_out;

endpackage

[hdl/epp_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
module epp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/encoder_preset_positioner.sv]
// Top level of the encoder preset positioner: dial tracking, preset table and step counts.
//
// Use of the block:
// Items enter on the input channel (i_in_valid / o_in_stall) and each one gives exactly
// one result item on the output channel (o_out_valid / i_out_stall). An item is taken at a
// rising edge with valid high and stall low. Encoder samples move the dial position by one
// count per valid Gray-code step, move requests look up a preset and report a direction and
// a step count, and button ticks count a consecutive hold that saves, clears or recenters.
// The register steps_per_rev is written through i_cfg_valid / o_cfg_ready / i_cfg_data;
// the user must do so only while the block is idle (no check); o_cfg_ready is always high.
//
// Timing: one item is worked on at a time. Samples, ticks and unused commands pass the
// execute step into the output register. A move passes the execute step on the preset entry
// read at acceptance, then distance times steps_per_rev, the reciprocal of the division by
// 90 and the finish step before it reaches the output register. The next item is taken once
// the block is back in idle. Each clear of the preset table (the seventh and the eleventh
// held tick) then holds o_in_stall high while the memory sweep writes every entry; the
// tick's result is delivered.
//
// Reset (synchronous, active low) recenters the dial to 127, clears the hold count and
// steps_per_rev goes to 200; it then sweeps the whole preset memory with the input
// stalled. A stalled receiver leaves the result in the output register, and one more item
// can be taken and computed behind it; that item then waits until the register is free.
module encoder_preset_positioner
    import epp_pkg::*;
#(
    parameter int NUM_PRESETS = EPP_NUM_PRESETS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  t_epp_in          i_in_data,
    output logic             o_in_stall,
    output logic             o_out_valid,
    output t_epp_out         o_out_data,
    input  logic             i_out_stall,
    input  logic             i_cfg_valid,
    input  logic [SPR_W-1:0] i_cfg_data,
    output logic             o_cfg_ready
);

    localparam int ADDR_W = $clog2(NUM_PRESETS);
    // Width that holds both a preset index and a memory address.
    localparam int XW     = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;
    localparam logic [XW:0]       PRESET_LIMIT = (XW + 1)'(NUM_PRESETS);
    localparam logic [ADDR_W-1:0] LAST_ADDR    = ADDR_W'(NUM_PRESETS - 1);
    // A memory entry is {valid, preset word}.
    localparam int MEM_W = POS_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL1,
        ST_MUL2,
        ST_FINISH
    } t_state;

    t_state            r_state, n_state;
    t_epp_in           r_item, n_item;
    logic [SPR_W-1:0]  r_spr, n_spr;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [1:0]        r_last, n_last;
    logic [HOLD_W-1:0] r_hold, n_hold;
    logic              r_move, n_move;
    logic              r_dir, n_dir;
    logic [POS_W-1:0]  r_diff, n_diff;
    logic [PROD_W-1:0] r_prod, n_prod;
    logic [BIG_W-1:0]  r_big, n_big;
    t_epp_out          r_res, n_res;
    logic              r_out_valid, n_out_valid;
    t_epp_out          r_out, n_out;
    logic              r_clr_active, n_clr_active;
    logic [ADDR_W-1:0] r_clr_addr, n_clr_addr;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [MEM_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [MEM_W-1:0]  ram_rdata;

    logic              save_we;
    logic [XW-1:0]     in_idx_ext;
    logic [XW-1:0]     item_idx_ext;
    logic              item_in_range;
    logic              accept;
    logic              out_free;

    // Working values of the execute and finish steps.
    t_epp_out          res;
    logic [3:0]        trans;
    logic [1:0]        code;
    logic [HOLD_W-1:0] hold_next;
    logic [POS_W-1:0]  word;
    logic [PROD_W:0]   rounded;
    logic [QUOT_W-1:0] quot;
    logic [STEP_W-1:0] steps;

    assign in_idx_ext    = XW'(i_in_data.preset_index);
    assign item_idx_ext  = XW'(r_item.preset_index);
    assign item_in_range = ({1'b0, item_idx_ext} < PRESET_LIMIT);

    assign o_in_stall  = (r_state != ST_IDLE) || r_clr_active;
    assign accept      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    // The preset is read as the item is taken, so its entry is ready in the execute step.
    assign ram_raddr = in_idx_ext[ADDR_W-1:0];

    // The clearing sweep owns the write port; a save never falls in a sweep because
    // no item is taken while one runs.
    always_comb begin
        if (r_clr_active) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = {1'b0, UNSET_WORD};
        end else begin
            ram_we    = save_we;
            ram_waddr = item_idx_ext[ADDR_W-1:0];
            ram_wdata = {1'b1, r_pos};
        end
    end

    epp_ram #(
        .WIDTH (MEM_W),
        .DEPTH (NUM_PRESETS)
    ) u_preset_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_item       = r_item;
        n_spr        = r_spr;
        n_pos        = r_pos;
        n_last       = r_last;
        n_hold       = r_hold;
        n_move       = r_move;
        n_dir        = r_dir;
        n_diff       = r_diff;
        n_prod       = r_prod;
        n_big        = r_big;
        n_res        = r_res;
        n_out        = r_out;
        n_out_valid  = r_out_valid && i_out_stall;
        n_clr_active = r_clr_active;
        n_clr_addr   = r_clr_addr;
        save_we      = 1'b0;
        res          = '0;
        code         = {r_item.pin_a, r_item.pin_b};
        trans        = {r_last, code};
        hold_next    = r_hold + 1'b1;
        word         = ram_rdata[POS_W-1:0];
        rounded      = '0;
        quot         = '0;
        steps        = '0;

        if (i_cfg_valid) begin
            n_spr = i_cfg_data;
        end

        if (r_clr_active) begin
            if (r_clr_addr == LAST_ADDR) begin
                n_clr_active = 1'b0;
            end else begin
                n_clr_addr = r_clr_addr + 1'b1;
            end
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_item  = i_in_data;
                    n_state = ST_EXEC;
                end
            end

            ST_EXEC: begin
                n_move = 1'b0;
                case (r_item.cmd)
                    CMD_SAMPLE: begin
                        case (trans) inside
                            ENC_UP_0, ENC_UP_1, ENC_UP_2, ENC_UP_3: n_pos = r_pos + 1'b1;
                            ENC_DN_0, ENC_DN_1, ENC_DN_2, ENC_DN_3: n_pos = r_pos - 1'b1;
                            default: ;
                        endcase
                        n_last = code;
                    end
                    CMD_MOVE: begin
                        n_move = item_in_range && ram_rdata[POS_W] && (word != UNSET_WORD);
                        n_dir  = (word > r_pos);
                        n_diff = (word > r_pos) ? (word - r_pos) : (r_pos - word);
                    end
                    CMD_TICK: begin
                        if (!r_item.button_pressed) begin
                            n_hold = '0;
                        end else begin
                            if (hold_next == HOLD_SAVE) begin
                                if (item_in_range) begin
                                    save_we         = 1'b1;
                                    res.action_code = ACT_SAVED;
                                end
                            end else if (hold_next == HOLD_CLEAR) begin
                                n_clr_active    = 1'b1;
                                n_clr_addr      = '0;
                                res.action_code = ACT_CLEARED;
                            end else if (hold_next == HOLD_RESET) begin
                                n_clr_active    = 1'b1;
                                n_clr_addr      = '0;
                                n_pos           = NEUTRAL_POS;
                                res.action_code = ACT_RESET;
                            end
                            n_hold = (hold_next >= HOLD_WRAP) ? '0 : hold_next;
                        end
                    end
                    default: ;
                endcase
                res.position = n_pos;

                if (r_item.cmd == CMD_MOVE) begin
                    n_res   = res;
                    n_state = ST_MUL1;
                end else if (out_free) begin
                    n_out       = res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end else begin
                    n_res   = res;
                    n_state = ST_FINISH;
                end
            end

            ST_MUL1: begin
                n_prod  = PROD_W'(r_diff) * PROD_W'(r_spr);
                n_state = ST_MUL2;
            end

            ST_MUL2: begin
                rounded = (PROD_W + 1)'(r_prod) + ROUND_UP;
                n_big   = BIG_W'(rounded[PROD_W-1:1]) * BIG_W'(RECIP_45);
                n_state = ST_FINISH;
            end

            ST_FINISH: begin
                res = r_res;
                if (r_move) begin
                    quot  = r_big[BIG_W-1:RECIP_SHIFT];
                    steps = (quot > STEP_MAX) ? STEP_MAX[STEP_W-1:0] : quot[STEP_W-1:0];
                    if (steps != '0) begin
                        res.drive_valid = 1'b1;
                        res.direction   = r_dir;
                        res.step_count  = steps;
                    end
                end
                if (out_free) begin
                    n_out       = res;
                    n_out_valid = 1'b1;
                    n_move      = 1'b0;
                    n_state     = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_spr        <= SPR_RESET;
            r_pos        <= NEUTRAL_POS;
            r_last       <= '0;
            r_hold       <= '0;
            r_move       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else begin
            r_state      <= n_state;
            r_spr        <= n_spr;
            r_pos        <= n_pos;
            r_last       <= n_last;
            r_hold       <= n_hold;
            r_move       <= n_move;
            r_out_valid  <= n_out_valid;
            r_clr_active <= n_clr_active;
            r_clr_addr   <= n_clr_addr;
        end
        r_item <= n_item;
        r_dir  <= n_dir;
        r_diff <= n_diff;
        r_prod <= n_prod;
        r_big  <= n_big;
        r_res  <= n_res;
        r_out  <= n_out;
    end

endmodule

[hdl/epp_checker.sv]
// Port-level assertions for the encoder preset positioner and their bind.
module epp_checker
    import epp_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_stall,
    input logic     o_out_valid,
    input t_epp_out o_out_data,
    input logic     i_out_stall
);

    // A result waiting on a stalled receiver stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed or vanished");

    // Only one item is in work: an accepted item closes the input for the next cycle.
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted two items in a row");

    // A result without a move carries no direction and no steps.
    a_no_move_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.drive_valid |->
            !o_out_data.direction && (o_out_data.step_count == '0))
        else $error("idle move fields not zero");

    // An issued move has a nonzero step count and reports no button action.
    a_move_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.drive_valid |->
            (o_out_data.step_count != '0) && (o_out_data.action_code == ACT_NONE))
        else $error("issued move with bad fields");

    // Reset empties the output register and closes the input for the memory sweep.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_stall)
        else $error("state after reset wrong");

endmodule

bind encoder_preset_positioner epp_checker u_epp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);

[bench/tb_encoder_preset_positioner.sv]
// Self-checking testbench for the encoder preset positioner, with its own prediction of every result item.
module tb_encoder_preset_positioner;
    import epp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_PRESETS    = EPP_NUM_PRESETS;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int MAX_GAP        = 13;

    // The fourth command code is not used by the block; an item with it only reports position.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // Clock, reset and the block's ports.
    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    t_epp_in          i_in_data   = '0;
    logic             o_in_stall;
    logic             o_out_valid;
    t_epp_out         o_out_data;
    logic             i_out_stall = 1'b0;
    logic             i_cfg_valid = 1'b0;
    logic [SPR_W-1:0] i_cfg_data  = '0;
    logic             o_cfg_ready;

    encoder_preset_positioner #(
        .NUM_PRESETS(NUM_PRESETS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready)
    );

    // A 2 ns clock period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Expected state of the dial, the preset table and the hold counter, kept in step
    // with every item the block accepts.
    logic [POS_W-1:0]  exp_pos;
    logic [1:0]        exp_last_code;
    logic [POS_W-1:0]  exp_word [NUM_PRESETS];
    logic              exp_set  [NUM_PRESETS];
    logic [HOLD_W-1:0] exp_hold;
    logic [SPR_W-1:0]  exp_spr;

    // A preset slot is only ever read by a move once a save has written it.
    bit                written_slot [NUM_PRESETS];
    int                saved_slots [$];

    // Result items predicted for accepted input items, oldest first.
    t_epp_out          pending_results [$];

    // Run statistics and error count.
    int                items_sent    = 0;
    int                results_seen  = 0;
    int                moves_seen    = 0;
    int                table_clears  = 0;
    int                spr_settings  = 1;
    int                error_count   = 0;
    int                cycle_count   = 0;

    // Idling control. gaps_on enables random waits on both sides; hold_seq asks the
    // hold-off process for one long receiver stall each time it is bumped.
    logic              gaps_on  = 1'b1;
    int                hold_seq = 0;
    logic              rx_hold  = 1'b0;
    int                rx_wait  = 0;

    // Every preset goes back to unset, as the block does on reset and on the clearing ticks.
    function automatic void wipe_expected_presets();
        for (int i = 0; i < NUM_PRESETS; i++) begin
            exp_set[i]  = 1'b0;
            exp_word[i] = UNSET_WORD;
        end
    endfunction

    // The next code one quadrature step up or down from the given one.
    function automatic logic [1:0] next_code(input logic [1:0] code, input bit up);
        logic [1:0] nxt;
        case (code)
            2'b00:   nxt = up ? 2'b10 : 2'b01;
            2'b10:   nxt = up ? 2'b11 : 2'b00;
            2'b11:   nxt = up ? 2'b01 : 2'b10;
            default: nxt = up ? 2'b00 : 2'b11;
        endcase
        return nxt;
    endfunction

    // Works out the result item of one accepted input item and advances the expected state.
    function automatic t_epp_out predict_result(input t_epp_in item);
        t_epp_out          res;
        logic [3:0]        trans;
        logic [POS_W-1:0]  target;
        longint unsigned   span;
        longint unsigned   steps;
        res = '0;
        case (item.cmd)
            CMD_SAMPLE: begin
                // The previous code and the new one together name the transition. A
                // repeated code or a jump of two steps leaves the dial where it is.
                trans = {exp_last_code, item.pin_a, item.pin_b};
                case (trans)
                    ENC_UP_0, ENC_UP_1, ENC_UP_2, ENC_UP_3: exp_pos = exp_pos + 1'b1;
                    ENC_DN_0, ENC_DN_1, ENC_DN_2, ENC_DN_3: exp_pos = exp_pos - 1'b1;
                    default: ;
                endcase
                exp_last_code = {item.pin_a, item.pin_b};
            end
            CMD_MOVE: begin
                // An unset slot, or one that holds the unset word, gives no move.
                if (exp_set[item.preset_index] && exp_word[item.preset_index] != UNSET_WORD) begin
                    target = exp_word[item.preset_index];
                    span   = (target > exp_pos) ? target - exp_pos : exp_pos - target;
                    steps  = (4 * span * exp_spr + 359) / 360;
                    if (steps > STEP_MAX) begin
                        steps = STEP_MAX;
                    end
                    // Equal positions and a zero steps_per_rev both come out as zero steps.
                    if (steps != 0) begin
                        res.drive_valid = 1'b1;
                        res.direction   = (target > exp_pos);
                        res.step_count  = steps[STEP_W-1:0];
                    end
                end
            end
            CMD_TICK: begin
                if (!item.button_pressed) begin
                    exp_hold = '0;
                end else begin
                    exp_hold = exp_hold + 1'b1;
                    // The index field is seven bits wide, so it always falls inside the table.
                    if (exp_hold == HOLD_SAVE) begin
                        exp_word[item.preset_index] = exp_pos;
                        exp_set[item.preset_index]  = 1'b1;
                        res.action_code = ACT_SAVED;
                        if (!written_slot[item.preset_index]) begin
                            written_slot[item.preset_index] = 1'b1;
                            saved_slots.push_back(item.preset_index);
                        end
                    end else if (exp_hold == HOLD_CLEAR) begin
                        wipe_expected_presets();
                        res.action_code = ACT_CLEARED;
                        table_clears++;
                    end else if (exp_hold == HOLD_RESET) begin
                        wipe_expected_presets();
                        exp_pos = NEUTRAL_POS;
                        res.action_code = ACT_RESET;
                        table_clears++;
                    end
                    if (exp_hold >= HOLD_WRAP) begin
                        exp_hold = '0;
                    end
                end
            end
            default: ;
        endcase
        res.position = exp_pos;
        return res;
    endfunction

    // Offers one item after a random gap and waits until the block takes it. The caller is
    // always at a rising edge, so valid and data change only there.
    task automatic send_item(input t_epp_in item);
        int gap;
        gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        pending_results.push_back(predict_result(item));
        items_sent++;
    endtask

    task automatic send_fields(input logic [CMD_W-1:0] cmd, input logic [1:0] code,
                               input logic [IDX_W-1:0] idx, input logic pressed);
        t_epp_in item;
        item.cmd            = cmd;
        item.pin_a          = code[1];
        item.pin_b          = code[0];
        item.preset_index   = idx;
        item.button_pressed = pressed;
        send_item(item);
    endtask

    task automatic send_sample(input logic [1:0] code);
        send_fields(CMD_SAMPLE, code, IDX_W'($urandom_range(0, 127)),
                    1'($urandom_range(0, 1)));
    endtask

    task automatic send_move(input logic [IDX_W-1:0] idx);
        send_fields(CMD_MOVE, 2'($urandom_range(0, 3)), idx, 1'($urandom_range(0, 1)));
    endtask

    task automatic send_tick(input logic pressed, input logic [IDX_W-1:0] idx);
        send_fields(CMD_TICK, 2'($urandom_range(0, 3)), idx, pressed);
    endtask

    // A held button for the given number of ticks, then one released tick.
    task automatic hold_button(input int ticks, input logic [IDX_W-1:0] idx);
        for (int i = 0; i < ticks; i++) begin
            send_tick(1'b1, idx);
        end
        send_tick(1'b0, idx);
    endtask

    // Stops offering items and waits until every predicted result has arrived, then long
    // enough for a preset table sweep to finish, so the block is idle afterwards.
    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (NUM_PRESETS + 16) @(posedge i_clk);
    endtask

    task automatic write_steps_per_rev(input logic [SPR_W-1:0] value);
        settle_block();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        exp_spr = value;
        spr_settings++;
    endtask

    // One unit of random traffic. Most of it is well-formed: proper encoder steps, moves to
    // saved presets and complete button holds. The rest is bad encoder codes, stray ticks
    // and the unused command.
    task automatic send_random_unit();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40 || (pick < 72 && saved_slots.size() == 0)) begin
            if ($urandom_range(0, 99) < 85) begin
                send_sample(next_code(exp_last_code, 1'($urandom_range(0, 1))));
            end else begin
                send_sample(2'($urandom_range(0, 3)));
            end
        end else if (pick < 72) begin
            send_move(IDX_W'(saved_slots[$urandom_range(0, saved_slots.size() - 1)]));
        end else if (pick < 92) begin
            // Short holds save presets; a few long ones reach the clearing ticks and the wrap.
            hold_button(($urandom_range(0, 9) < 8) ? $urandom_range(1, 5) : $urandom_range(6, 20),
                        IDX_W'($urandom_range(0, 127)));
        end else if (pick < 96) begin
            send_tick(1'($urandom_range(0, 1)), IDX_W'($urandom_range(0, 127)));
        end else begin
            send_fields(CMD_UNUSED, 2'($urandom_range(0, 3)), IDX_W'($urandom_range(0, 127)),
                        1'($urandom_range(0, 1)));
        end
    endtask

    // Every one of the sixteen code transitions, saving a preset, a move to the current
    // position, the unused command, and a one-count move.
    task automatic test_directed_basics();
        logic [1:0] walk [16] = '{2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3, 2'd3, 2'd0,
                                  2'd2, 2'd0, 2'd3, 2'd1, 2'd3, 2'd2, 2'd1, 2'd0};
        for (int i = 0; i < 16; i++) begin
            send_sample(walk[i]);
        end
        send_tick(1'b0, 7'd0);
        send_tick(1'b1, 7'd0);
        send_tick(1'b1, 7'd127);
        send_tick(1'b0, 7'd127);
        send_move(7'd127);
        send_fields(CMD_UNUSED, 2'b11, 7'd127, 1'b1);
        send_sample(next_code(exp_last_code, 1'b1));
        send_move(7'd127);
    endtask

    // Wraps the dial both ways, saves position 0 and the unset word 255, and moves the
    // longest distance.
    task automatic test_dial_wrap_and_unset_word();
        while (exp_pos != '0) begin
            send_sample(next_code(exp_last_code, 1'b0));
        end
        hold_button(2, 7'd6);
        send_sample(next_code(exp_last_code, 1'b0));
        hold_button(2, 7'd5);
        send_move(7'd5);
        send_move(7'd6);
        send_sample(next_code(exp_last_code, 1'b1));
        send_move(7'd6);
        send_sample(next_code(exp_last_code, 1'b0));
    endtask

    // The register at its extremes: one step, 4096 as the top of the random range, all ones so
    // that the longest move saturates, zero so that no move is issued, and back to the reset value.
    task automatic test_register_extremes();
        logic [SPR_W-1:0] values [5] = '{13'd1, 13'd4096, 13'd8191, 13'd0, SPR_RESET};
        for (int i = 0; i < 5; i++) begin
            write_steps_per_rev(values[i]);
            send_move(7'd6);
            send_move(7'd5);
            send_move(7'd127);
        end
    endtask

    // A twenty-tick hold passes the save, both clears, the recenter and the wrap of the
    // count, then saves again. A seven-tick hold saves and at once clears the table.
    task automatic test_hold_sequences();
        hold_button(20, 7'd9);
        send_move(7'd9);
        send_sample(next_code(exp_last_code, 1'b1));
        send_sample(next_code(exp_last_code, 1'b1));
        send_move(7'd9);
        hold_button(7, 7'd10);
        send_move(7'd10);
        send_move(7'd9);
        send_tick(1'b0, 7'd0);
    endtask

    // The receiver holds off for a long stretch while items keep coming without gaps, so
    // the block fills up and stalls its input.
    task automatic test_output_holdoff();
        int stop_at;
        stop_at = items_sent + 40;
        gaps_on  <= 1'b0;
        hold_seq <= hold_seq + 1;
        while (items_sent < stop_at) begin
            send_random_unit();
        end
        gaps_on <= 1'b1;
    endtask

    // The sender pauses until every result has come, then goes on.
    task automatic test_sender_pause();
        repeat (12) send_random_unit();
        settle_block();
        repeat (12) send_random_unit();
    endtask

    // Random traffic in phases with a fresh steps_per_rev before each but the first; one phase
    // runs with no idling on either side.
    task automatic test_random_traffic();
        int stop_at;
        for (int phase = 0; phase < 6; phase++) begin
            if (phase != 0) begin
                write_steps_per_rev((phase == 4) ? 13'd4096 : SPR_W'($urandom_range(1, 4096)));
            end
            gaps_on <= (phase != 2);
            stop_at = items_sent + 250;
            while (items_sent < stop_at) begin
                send_random_unit();
            end
        end
        gaps_on <= 1'b1;
    endtask

    // Compares one field of a result item with its prediction.
    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $error("Field %s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // Receiver: checks each accepted result item against the oldest prediction, then draws
    // how long to stall before taking the next one. The long hold-off overrides that.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            t_epp_out want;
            if (pending_results.size() == 0) begin
                $error("Result item arrived with no prediction waiting");
                error_count++;
            end else begin
                want = pending_results.pop_front();
                compare_field("drive_valid", want.drive_valid, o_out_data.drive_valid);
                compare_field("direction",   want.direction,   o_out_data.direction);
                compare_field("step_count",  want.step_count,  o_out_data.step_count);
                compare_field("position",    want.position,    o_out_data.position);
                compare_field("action_code", want.action_code, o_out_data.action_code);
                if (want.drive_valid) begin
                    moves_seen++;
                end
            end
            results_seen++;
            rx_wait = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        end else if (rx_wait > 0) begin
            rx_wait = rx_wait - 1;
        end
        i_out_stall <= rx_hold || (rx_wait != 0);
    end

    // Long receiver hold-off, counted here in cycles whenever a test asks for one.
    initial begin : rx_holdoff
        int seen;
        seen = 0;
        forever begin
            @(posedge i_clk);
            if (hold_seq != seen) begin
                seen = hold_seq;
                rx_hold <= 1'b1;
                repeat (HOLDOFF_CYCLES) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
        end
    end

    // Guard against a hang anywhere in the run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        // State right after reset: dial centered, code zero, table unset, reset register.
        exp_pos       = NEUTRAL_POS;
        exp_last_code = 2'b00;
        exp_hold      = '0;
        exp_spr       = SPR_RESET;
        wipe_expected_presets();
        for (int i = 0; i < NUM_PRESETS; i++) begin
            written_slot[i] = 1'b0;
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_basics();
        test_dial_wrap_and_unset_word();
        test_register_extremes();
        test_hold_sequences();
        test_output_holdoff();
        test_sender_pause();
        test_random_traffic();
        settle_block();

        if (pending_results.size() != 0) begin
            $error("%0d predicted results never arrived", pending_results.size());
            error_count++;
        end

        $display("Checked %0d items and %0d results, %0d of them issued moves, with %0d table clears",
                 items_sent, results_seen, moves_seen, table_clears);
        $display("over %0d steps_per_rev settings, including zero, one and saturating values.",
                 spr_settings);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
